### src/gbco_pkg.sv
// ----------------------------------------------------------------------------
// gbco_pkg
// Shared constants, payload types and controller/datapath interface types of
// the greedy bitset colour ordering block.
// ----------------------------------------------------------------------------
package gbco_pkg;

    // Largest graph handled; sets the depth of the adjacency memory.
    localparam int MAX_VERTICES = 64;
    localparam int ROW_W        = $clog2(MAX_VERTICES);

    // Field widths fixed by the item format.
    localparam int OPCODE_W = 2;
    localparam int VERT_W   = 6;
    localparam int WORD_W   = 64;
    localparam int COLOUR_W = 7;
    localparam int VC_W     = 7;

    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_WRITE_ROW  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_WRITE_CAND = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_START      = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VERT_W-1:0]   row_index;
        logic [WORD_W-1:0]   bit_word;
    } in_item_t;

    typedef struct packed {
        logic [VERT_W-1:0]   vertex;
        logic [COLOUR_W-1:0] colour;
        logic                none;
        logic                last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_PICK,
        ST_APPLY
    } gbco_state_t;

    typedef struct packed {
        logic write_row;
        logic write_cand;
        logic start;
        logic emit_none;
        logic pick;
        logic apply;
    } gbco_cmd_t;

    typedef struct packed {
        logic start_empty;
        logic left_empty;
        logic out_free;
    } gbco_status_t;

endpackage

### src/gbco_ram.sv
// ----------------------------------------------------------------------------
// gbco_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gbco_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/gbco_ctrl.sv
// ----------------------------------------------------------------------------
// gbco_ctrl
// Sequencer of the colouring run: takes items in idle and steps the datapath
// through one pick and one neighbour removal per coloured vertex.
// ----------------------------------------------------------------------------
module gbco_ctrl
    import gbco_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic [OPCODE_W-1:0] opcode,
    output logic                s_ready,
    input  gbco_status_t        status,
    output gbco_cmd_t           cmd
);

    gbco_state_t state_reg;
    gbco_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (opcode)
                        OP_WRITE_ROW:  cmd.write_row  = 1'b1;
                        OP_WRITE_CAND: cmd.write_cand = 1'b1;
                        OP_START:      state_next     = ST_START;
                        default:       ;
                    endcase
                end
            end
            ST_START: begin
                if (status.start_empty) begin
                    if (status.out_free) begin
                        cmd.emit_none = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (status.out_free) begin
                    cmd.pick   = 1'b1;
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply  = 1'b1;
                state_next = status.left_empty ? ST_IDLE : ST_PICK;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### src/gbco_dpath.sv
// ----------------------------------------------------------------------------
// gbco_dpath
// Datapath: adjacency memory, candidate set, remaining and open vertex sets,
// colour counter and the result register.
// ----------------------------------------------------------------------------
module gbco_dpath
    import gbco_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  in_item_t        s_item,
    input  logic [VC_W-1:0] vertex_count,
    input  gbco_cmd_t       cmd,
    output gbco_status_t    status,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_item
);

    // Bits of the vertices in use: those below the clamped vertex count.
    function automatic logic [WORD_W-1:0] in_use_mask(input logic [VC_W-1:0] n);
        logic [VC_W-1:0]   lim;
        logic [WORD_W-1:0] m;
        lim = (n > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : n;
        for (int j = 0; j < WORD_W; j++) begin
            m[j] = (VC_W'(j) < lim);
        end
        return m;
    endfunction

    // Index of a one-hot word, built as an OR tree per index bit.
    function automatic logic [VERT_W-1:0] onehot_index(input logic [WORD_W-1:0] oh);
        logic [VERT_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < VERT_W; b++) begin
            for (int j = 0; j < WORD_W; j++) begin
                if (((j >> b) & 1) == 1) begin
                    idx[b] = idx[b] | oh[j];
                end
            end
        end
        return idx;
    endfunction

    logic [WORD_W-1:0]   cand_reg;
    logic [WORD_W-1:0]   left_reg, left_next;
    logic [WORD_W-1:0]   open_reg, open_next;
    logic [COLOUR_W-1:0] colour_reg, colour_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic [WORD_W-1:0] start_set;
    logic [WORD_W-1:0] low_bit;
    logic [VERT_W-1:0] low_index;
    logic [WORD_W-1:0] row_data;
    logic [WORD_W-1:0] open_rem;
    logic              row_we;

    assign start_set = cand_reg & in_use_mask(vertex_count);
    assign low_bit   = open_reg & (~open_reg + WORD_W'(1));
    assign low_index = onehot_index(low_bit);
    assign open_rem  = open_reg & ~row_data;
    assign row_we    = cmd.write_row &&
                       ({1'b0, s_item.row_index} < (VERT_W + 1)'(MAX_VERTICES));

    gbco_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (s_item.row_index[ROW_W-1:0]),
        .wdata (s_item.bit_word),
        .raddr (low_index[ROW_W-1:0]),
        .rdata (row_data)
    );

    assign status.start_empty = (start_set == '0);
    assign status.left_empty  = (left_reg == '0);
    assign status.out_free    = !out_valid_reg || m_ready;

    always_comb begin
        left_next      = left_reg;
        open_next      = open_reg;
        colour_next    = colour_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_item_next  = out_item_reg;
        if (cmd.start) begin
            left_next   = start_set;
            open_next   = start_set;
            colour_next = COLOUR_W'(1);
        end
        if (cmd.emit_none) begin
            out_valid_next = 1'b1;
            out_item_next  = '{vertex: '0, colour: '0, none: 1'b1, last: 1'b1};
        end
        if (cmd.pick) begin
            left_next      = left_reg & ~low_bit;
            open_next      = open_reg & ~low_bit;
            out_valid_next = 1'b1;
            out_item_next  = '{vertex: low_index, colour: colour_reg, none: 1'b0,
                               last: ((left_reg & ~low_bit) == '0)};
        end
        if (cmd.apply && (left_reg != '0)) begin
            // An exhausted colour class opens the next one over what is left.
            if (open_rem == '0) begin
                open_next   = left_reg;
                colour_next = colour_reg + COLOUR_W'(1);
            end else begin
                open_next = open_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.write_cand) begin
                cand_reg <= s_item.bit_word;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg     <= left_next;
        open_reg     <= open_next;
        colour_reg   <= colour_next;
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

### src/greedy_bitset_colour_order_top.sv
// ----------------------------------------------------------------------------
// greedy_bitset_colour_order_top
// Greedy sequential colouring of a candidate vertex set over a bit adjacency
// matrix, with an APB-style register for the number of vertices in use.
// ----------------------------------------------------------------------------
// Usage: the input channel (s_valid, s_ready, s_item) carries one transaction
// per item. An adjacency row write or a candidate set write gives no result.
// A start transaction colours the candidate set and the block emits one
// result transaction per coloured vertex on the output channel (m_valid,
// m_ready, m_item), the final one marked by last. An empty candidate set
// yields a single result with none and last set.
// Runs: the block takes one start at a time and is not ready for further
// input while a run is in progress. Each vertex needs a lowest-bit pick,
// which issues the adjacency memory read, and an apply step in which the
// registered row removes the neighbours from the open set; a new colour
// class is opened within that apply step. The first result is registered
// by the first pick, which follows the start step.
// Stalls: the result sits in an output register; while the receiver holds
// m_ready low the run pauses at the next pick and resumes when it is freed.
// Reset: aresetn clears the candidate set, the pending result and the
// sequencer, and sets vertex_count to 64. Adjacency rows are not cleared and
// must be written before a start uses them.
// ----------------------------------------------------------------------------
module greedy_bitset_colour_order_top
    import gbco_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // APB-style configuration port.
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Input channel.
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_item,
    // Result channel.
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_item
);

    logic [VC_W-1:0] vertex_count_reg;
    logic            reg_sel;
    gbco_cmd_t       cmd;
    gbco_status_t    status;

    // Registers lie at word addresses, so the index is the address above the
    // byte offset.
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vertex_count_reg <= VC_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (reg_sel == REG_VERTEX_COUNT)) begin
            vertex_count_reg <= pwdata[VC_W-1:0];
        end
    end

    // Addresses with no register behind them read as zero.
    assign prdata = (reg_sel == REG_VERTEX_COUNT) ?
                    {{(PDATA_W - VC_W){1'b0}}, vertex_count_reg} : '0;

    gbco_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .opcode  (s_item.opcode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gbco_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_item       (s_item),
        .vertex_count (vertex_count_reg),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item)
    );

endmodule
